// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion helpers for the hue gradient RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BHG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A same-cycle implication.
`define BHG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bhg_pkg.sv =====
// bhg_pkg: types and constants shared by the hue gradient modules.
// No dependencies; every module of the block imports it.
package bhg_pkg;

  localparam int unsigned HUE_W   = 16;
  localparam int unsigned LAYERS  = 2;
  localparam int unsigned CORNERS = 4;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned QUOT_W  = 24;  // |hue difference| times coordinate
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned CNT_W   = $clog2(QDEPTH + 1);
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;

  // Corner hue reset values, corner 0 in the lowest slot.
  localparam logic [HUE_W-1:0] HUE_MID = 16'd32766;
  localparam logic [HUE_W-1:0] HUE_TOP = 16'd65534;
  localparam logic [CORNERS-1:0][HUE_W-1:0] HUE_RST = {HUE_TOP, HUE_MID, HUE_MID, 16'd0};
  localparam logic [HUE_W-1:0] OFFSET_RST = 16'd1;

  typedef enum logic [2:0] {
    FUNC_TICK        = 3'd0,
    FUNC_PIXEL       = 3'd1,
    FUNC_LOAD_CORNER = 3'd2,
    FUNC_LOAD_OFFSET = 3'd3,
    FUNC_SWAP        = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    REG_SAT0 = 2'd0,
    REG_VAL0 = 2'd1,
    REG_SAT1 = 2'd2,
    REG_VAL1 = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    TAG_X0 = 2'd0,
    TAG_X1 = 2'd1,
    TAG_Y  = 2'd2
  } lerp_tag_e;

  typedef struct packed {
    func_e             func;
    logic              layer;
    logic [1:0]        corner;
    logic [7:0]        pixel_x;
    logic [3:0]        pixel_y;
    logic [HUE_W-1:0]  hue_value;
    logic [HUE_W-1:0]  speed_value;
  } cmd_t;

  typedef struct packed {
    logic [LAYERS-1:0][CFG_W-1:0] sat;
    logic [LAYERS-1:0][CFG_W-1:0] val;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    lerp_tag_e         tag;
    logic              use_y;
    logic [HUE_W-1:0]  a;
    logic [HUE_W-1:0]  b;
    logic [7:0]        pos;
  } lerp_req_t;

  typedef struct packed {
    logic              valid;
    lerp_tag_e         tag;
    logic [HUE_W-1:0]  hue;
  } lerp_rsp_t;

  typedef struct packed {
    lerp_tag_e         tag;
    logic              use_y;
    logic              neg;
    logic [HUE_W-1:0]  a;
  } lerp_meta_t;

  typedef struct packed {
    logic [CFG_W-1:0]  brightness;
    logic [CFG_W-1:0]  saturation;
    logic [HUE_W-1:0]  hue;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } front_status_t;

  typedef struct packed {
    logic lerp_done;
    logic waiting;
    logic emit_fire;
  } back_status_t;

endpackage

// ===== rtl/bhg_front.sv =====
// bhg_front: accepts input transactions, decodes them into commands and
// queues them for the back end. Depends on bhg_pkg.
module bhg_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  // layer, corner, pixel_x, pixel_y, hue_value, speed_value, zero pad
  input  logic [bhg_pkg::IN_TDATA_W-1:0]   in_data_i,
  // func
  input  logic [2:0]                       in_user_i,
  output bhg_pkg::cmd_t                    cmd_o,
  output logic                             cmd_valid_o,
  input  logic                             cmd_pop_i,
  output bhg_pkg::front_status_t           status_o
);
  import bhg_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);

  cmd_t            cmd_in;
  logic            known_func;
  logic            push;
  logic            pop;
  cmd_t            queue_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  always_comb begin
    cmd_in.func        = func_e'(in_user_i);
    cmd_in.layer       = in_data_i[0];
    cmd_in.corner      = in_data_i[2:1];
    cmd_in.pixel_x     = in_data_i[10:3];
    cmd_in.pixel_y     = in_data_i[14:11];
    cmd_in.hue_value   = in_data_i[30:15];
    cmd_in.speed_value = in_data_i[46:31];
  end

  // Unused function codes are taken off the bus and dropped here.
  always_comb begin
    case (cmd_in.func)
      FUNC_TICK, FUNC_PIXEL, FUNC_LOAD_CORNER, FUNC_LOAD_OFFSET, FUNC_SWAP: known_func = 1'b1;
      default: known_func = 1'b0;
    endcase
  end

  assign in_ready_o  = (count_q != CNT_W'(QDEPTH));
  assign push        = in_valid_i && in_ready_o && known_func;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];
  assign status_o.count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cmd_in;
  end

endmodule

// ===== rtl/bhg_lerp.sv =====
// bhg_lerp: six-stage pipeline computing a + trunc((b - a) * pos / span)
// modulo 2^16, span chosen per request. Depends on bhg_pkg.
module bhg_lerp #(
  parameter int unsigned SpanX = 48,
  parameter int unsigned SpanY = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bhg_pkg::lerp_req_t  req_i,
  output bhg_pkg::lerp_rsp_t  rsp_o
);
  import bhg_pkg::*;

  localparam int unsigned Stages = 6;
  localparam int unsigned RecipW = QUOT_W + 1;
  localparam int unsigned ProdW  = QUOT_W + RecipW;
  // floor(2^24 / span): the estimate is low by at most one, fixed in stage 4.
  localparam logic [RecipW-1:0] RECIP_X = RecipW'((1 << QUOT_W) / SpanX);
  localparam logic [RecipW-1:0] RECIP_Y = RecipW'((1 << QUOT_W) / SpanY);
  localparam logic [7:0] SPAN_X8 = 8'(SpanX);
  localparam logic [7:0] SPAN_Y8 = 8'(SpanY);

  logic [Stages-1:0]   vld_q;
  lerp_meta_t          meta_q [Stages];
  lerp_meta_t          meta_d;
  logic [HUE_W-1:0]    mag_d;
  logic [HUE_W-1:0]    mag0_q;
  logic [7:0]          pos0_q;
  logic [QUOT_W-1:0]   n1_q, n2_q, n3_q;
  logic [ProdW-1:0]    prod2;
  logic [QUOT_W-1:0]   q2_q, q3_q;
  logic [31:0]         m3_q;
  logic [QUOT_W-1:0]   rem4;
  logic [7:0]          span3;
  logic [HUE_W-1:0]    qf4_q;
  logic [HUE_W-1:0]    hue5_q;

  always_comb begin
    meta_d.tag   = req_i.tag;
    meta_d.use_y = req_i.use_y;
    meta_d.a     = req_i.a;
    meta_d.neg   = (req_i.b < req_i.a);
    mag_d        = meta_d.neg ? (req_i.a - req_i.b) : (req_i.b - req_i.a);
  end

  assign prod2 = ProdW'(n1_q) * ProdW'(meta_q[1].use_y ? RECIP_Y : RECIP_X);
  assign span3 = meta_q[3].use_y ? SPAN_Y8 : SPAN_X8;
  assign rem4  = n3_q - m3_q[QUOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_d;
    for (int i = 1; i < Stages; i++) meta_q[i] <= meta_q[i-1];
    mag0_q <= mag_d;
    pos0_q <= req_i.pos;
    n1_q   <= QUOT_W'(mag0_q) * QUOT_W'(pos0_q);
    q2_q   <= prod2[ProdW-2 -: QUOT_W];
    n2_q   <= n1_q;
    m3_q   <= 32'(q2_q) * 32'(meta_q[2].use_y ? SPAN_Y8 : SPAN_X8);
    q3_q   <= q2_q;
    n3_q   <= n2_q;
    qf4_q  <= q3_q[HUE_W-1:0] + HUE_W'(rem4 >= QUOT_W'(span3));
    hue5_q <= meta_q[4].neg ? (meta_q[4].a - qf4_q) : (meta_q[4].a + qf4_q);
  end

  assign rsp_o.valid = vld_q[Stages-1];
  assign rsp_o.tag   = meta_q[Stages-1].tag;
  assign rsp_o.hue   = hue5_q;

endmodule

// ===== rtl/bhg_back.sv =====
// bhg_back: holds the corner and offset state, executes queued commands and
// sequences the three interpolation passes of a pixel. Depends on bhg_pkg.
module bhg_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bhg_pkg::cmd_t           cmd_i,
  input  logic                    cmd_valid_i,
  output logic                    cmd_pop_o,
  input  bhg_pkg::cfg_t           cfg_i,
  output bhg_pkg::lerp_req_t      lerp_req_o,
  input  bhg_pkg::lerp_rsp_t      lerp_rsp_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bhg_pkg::out_t           out_data_o,
  output bhg_pkg::back_status_t   status_o
);
  import bhg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ISSUE_X0 = 7'b0000010,
    S_ISSUE_X1 = 7'b0000100,
    S_WAIT_X   = 7'b0001000,
    S_ISSUE_Y  = 7'b0010000,
    S_WAIT_Y   = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic             emit;
  cmd_t             cur_q;
  logic [HUE_W-1:0] h0_q, h1_q, hy_q;
  logic [HUE_W-1:0] hue_q    [LAYERS][CORNERS];
  logic [HUE_W-1:0] speed_q  [LAYERS][CORNERS];
  logic [HUE_W-1:0] offset_q [LAYERS];
  logic [HUE_W-1:0] ospeed_q [LAYERS];
  logic             out_valid_q;
  out_t             out_data_q;

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    lerp_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.func == FUNC_PIXEL) state_d = S_ISSUE_X0;
        end
      end
      S_ISSUE_X0: begin
        lerp_req_o.valid = 1'b1;
        lerp_req_o.tag   = TAG_X0;
        lerp_req_o.a     = hue_q[cur_q.layer][0];
        lerp_req_o.b     = hue_q[cur_q.layer][1];
        lerp_req_o.pos   = cur_q.pixel_x;
        state_d          = S_ISSUE_X1;
      end
      S_ISSUE_X1: begin
        lerp_req_o.valid = 1'b1;
        lerp_req_o.tag   = TAG_X1;
        lerp_req_o.a     = hue_q[cur_q.layer][2];
        lerp_req_o.b     = hue_q[cur_q.layer][3];
        lerp_req_o.pos   = cur_q.pixel_x;
        state_d          = S_WAIT_X;
      end
      S_WAIT_X: begin
        if (lerp_rsp_i.valid && lerp_rsp_i.tag == TAG_X1) state_d = S_ISSUE_Y;
      end
      S_ISSUE_Y: begin
        lerp_req_o.valid = 1'b1;
        lerp_req_o.tag   = TAG_Y;
        lerp_req_o.use_y = 1'b1;
        lerp_req_o.a     = h0_q;
        lerp_req_o.b     = h1_q;
        lerp_req_o.pos   = {4'b0, cur_q.pixel_y};
        state_d          = S_WAIT_Y;
      end
      S_WAIT_Y: begin
        if (lerp_rsp_i.valid && lerp_rsp_i.tag == TAG_Y) state_d = S_EMIT;
      end
      S_EMIT: begin
        // The output register takes the result once its previous one has left.
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Layer state: ticks, loads and swaps complete in the cycle they are popped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LAYERS; l++) begin
        for (int c = 0; c < CORNERS; c++) begin
          hue_q[l][c]   <= HUE_RST[c];
          speed_q[l][c] <= '0;
        end
        offset_q[l] <= OFFSET_RST;
        ospeed_q[l] <= '0;
      end
    end else if (cmd_pop_o) begin
      case (cmd_i.func)
        FUNC_TICK: begin
          offset_q[cmd_i.layer] <= offset_q[cmd_i.layer] + ospeed_q[cmd_i.layer];
          for (int c = 0; c < CORNERS; c++) begin
            hue_q[cmd_i.layer][c] <= hue_q[cmd_i.layer][c] + speed_q[cmd_i.layer][c];
          end
        end
        FUNC_LOAD_CORNER: begin
          hue_q[cmd_i.layer][cmd_i.corner]   <= cmd_i.hue_value;
          speed_q[cmd_i.layer][cmd_i.corner] <= cmd_i.speed_value;
        end
        FUNC_LOAD_OFFSET: begin
          ospeed_q[cmd_i.layer] <= cmd_i.speed_value;
        end
        FUNC_SWAP: begin
          hue_q[0] <= hue_q[1];
          hue_q[1] <= hue_q[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
    if (lerp_rsp_i.valid && lerp_rsp_i.tag == TAG_X0) h0_q <= lerp_rsp_i.hue;
    if (lerp_rsp_i.valid && lerp_rsp_i.tag == TAG_X1) h1_q <= lerp_rsp_i.hue;
    if (lerp_rsp_i.valid && lerp_rsp_i.tag == TAG_Y)  hy_q <= lerp_rsp_i.hue;
    if (emit) begin
      out_data_q.hue        <= hy_q + offset_q[cur_q.layer];
      out_data_q.saturation <= cfg_i.sat[cur_q.layer];
      out_data_q.brightness <= cfg_i.val[cur_q.layer];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;
  assign status_o.lerp_done = lerp_rsp_i.valid;
  assign status_o.waiting   = (state_q == S_WAIT_X) || (state_q == S_WAIT_Y);
  assign status_o.emit_fire = emit;

endmodule

// ===== rtl/bilinear_hue_gradient.sv =====
// bilinear_hue_gradient: two-layer bilinear hue gradient for an LED display.
// The back end works on one pixel at a time, through three passes of the
// six-stage interpolation pipeline, and retires a tick, load or swap in the
// cycle it is popped. A two-entry queue keeps the input open while the back
// end is busy, until both of its entries are full.
// Reset (rst_ni low, asynchronous) restores corner hues, speeds, offsets and
// sets all four saturation and brightness registers to 255.
`include "assert_macros.svh"

module bilinear_hue_gradient #(
  parameter int unsigned SPAN_X = 48,
  parameter int unsigned SPAN_Y = 11
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // layer[0], corner[2:1], pixel_x[10:3], pixel_y[14:11], hue_value[30:15],
  // speed_value[46:31], zero pad[47]
  input  logic [47:0]  s_axis_tdata,
  // func[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hue[15:0], saturation[23:16], brightness[31:24]
  output logic [31:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bhg_pkg::*;

  cmd_t          cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  cfg_t          cfg_q;
  lerp_req_t     lerp_req;
  lerp_rsp_t     lerp_rsp;
  out_t          out_data;
  front_status_t fr_status;
  back_status_t  bk_status;
  reg_idx_e      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '1;  // every register resets to 255
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_SAT0: cfg_q.sat[0] <= pwdata[CFG_W-1:0];
        REG_VAL0: cfg_q.val[0] <= pwdata[CFG_W-1:0];
        REG_SAT1: cfg_q.sat[1] <= pwdata[CFG_W-1:0];
        REG_VAL1: cfg_q.val[1] <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SAT0: prdata = 32'(cfg_q.sat[0]);
      REG_VAL0: prdata = 32'(cfg_q.val[0]);
      REG_SAT1: prdata = 32'(cfg_q.sat[1]);
      REG_VAL1: prdata = 32'(cfg_q.val[1]);
      default:  prdata = '0;
    endcase
  end

  bhg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .status_o    (fr_status)
  );

  bhg_lerp #(
    .SpanX (SPAN_X),
    .SpanY (SPAN_Y)
  ) u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  bhg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .lerp_req_o  (lerp_req),
    .lerp_rsp_i  (lerp_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data),
    .status_o    (bk_status)
  );

  assign m_axis_tdata = out_data;

  `BHG_ASSERT(a_queue_bound, fr_status.count <= CNT_W'(QDEPTH), "command queue overfilled")
  `BHG_ASSERT_IMPL(a_rsp_expected, bk_status.lerp_done, bk_status.waiting, "unexpected interpolation result")
  `BHG_ASSERT_IMPL(a_emit_slot_free, bk_status.emit_fire, !m_axis_tvalid || m_axis_tready, "result overwrites a pending transaction")
  `BHG_ASSERT_IMPL(a_pop_has_cmd, cmd_pop, cmd_valid, "pop from an empty command queue")

endmodule
